FILE: hw/rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the box proximity clustering block.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int GAP_BITS = 12;
	localparam int CLUSTER_BITS = 6;

	localparam logic [1:0] REG_ROW_GAP = 2'd0;
	localparam logic [1:0] REG_COL_BASE = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;

	localparam logic [GAP_BITS-1:0] ROW_GAP_RST = 12'd50;
	localparam logic [GAP_BITS-1:0] COL_BASE_RST = 12'd27;

	typedef struct packed {
		logic [GAP_BITS-1:0] row_gap;
		logic [GAP_BITS-1:0] col_base;
		logic                mode;
	} rule_cfg_t;

endpackage

FILE: hw/rtl/bpc_pair_test.sv
// ----------------------------------------------------------------------------
// bpc_pair_test
// Two-stage pair test unit: row rule and optional column rule on two boxes.
// ----------------------------------------------------------------------------
module bpc_pair_test import bpc_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [4*COORD_BITS-1:0] box_p,   // x, y, w, h from low bits
	input  logic [4*COORD_BITS-1:0] box_q,
	input  rule_cfg_t               cfg,
	output logic                    done,
	output logic                    join_ok
);

	localparam int CB = COORD_BITS;
	localparam int W = ((CB > GAP_BITS) ? CB : GAP_BITS) + 7;

	logic signed [W-1:0] px, py, pw, ph, qx, qy, qw, qh;
	logic signed [W-1:0] ay, by, ax, bx, dx, dy;

	logic signed [W-1:0] ay_s1, by_s1, ax_s1, bx_s1, dcx_s1, dcy_s1;
	logic signed [W-1:0] pw_s1, ph_s1, qw_s1, qh_s1;
	logic                vld_s1;

	logic signed [W-1:0] hs, ws, cy, cx, my, mx, rg, cg;
	logic                row_ok, col_ok;

	assign px = W'(box_p[CB-1:0]);
	assign py = W'(box_p[2*CB-1:CB]);
	assign pw = W'(box_p[3*CB-1:2*CB]);
	assign ph = W'(box_p[4*CB-1:3*CB]);
	assign qx = W'(box_q[CB-1:0]);
	assign qy = W'(box_q[2*CB-1:CB]);
	assign qw = W'(box_q[3*CB-1:2*CB]);
	assign qh = W'(box_q[4*CB-1:3*CB]);

	assign ay = py - qy - qh;
	assign by = qy - py - ph;
	assign ax = px - qx - qw;
	assign bx = qx - px - pw;
	assign dx = (px + (pw >>> 1)) - (qx + (qw >>> 1));
	assign dy = (py + (ph >>> 1)) - (qy + (qh >>> 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= start;
			done <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ay_s1 <= (ay < 0) ? -ay : ay;
		by_s1 <= (by < 0) ? -by : by;
		ax_s1 <= (ax < 0) ? -ax : ax;
		bx_s1 <= (bx < 0) ? -bx : bx;
		dcx_s1 <= (dx < 0) ? -dx : dx;
		dcy_s1 <= (dy < 0) ? -dy : dy;
		pw_s1 <= pw;
		ph_s1 <= ph;
		qw_s1 <= qw;
		qh_s1 <= qh;
	end

	assign hs = ph_s1 + qh_s1;
	assign ws = pw_s1 + qw_s1;
	assign cy = (ay_s1 < by_s1) ? ay_s1 : by_s1;
	assign my = (ay_s1 < by_s1) ? by_s1 : ay_s1;
	assign cx = (ax_s1 < bx_s1) ? ax_s1 : bx_s1;
	assign mx = (ax_s1 < bx_s1) ? bx_s1 : ax_s1;
	assign rg = W'(cfg.row_gap);
	assign cg = W'(cfg.col_base);

	always_comb begin
		row_ok = (my < hs)
			&& ((((cy <<< 3) + (cy <<< 1)) > ((ph_s1 <<< 3) - ph_s1))
			|| (((cy <<< 3) + (cy <<< 1)) > ((qh_s1 <<< 3) - qh_s1)))
			&& (((ph_s1 <<< 3) + (ph_s1 <<< 1)) < ((qh_s1 <<< 4) + qh_s1))
			&& (((qh_s1 <<< 3) + (qh_s1 <<< 1)) < ((ph_s1 <<< 4) + ph_s1))
			&& (((dcx_s1 <<< 1) - ws) < (rg <<< 1));
		col_ok = (mx < ws)
			&& (((cx <<< 1) > pw_s1) || ((cx <<< 1) > qw_s1))
			&& ((((dcy_s1 <<< 3) + (dcy_s1 <<< 1)) - ((hs <<< 2) + hs))
			< ((cg <<< 3) + (cg <<< 2) + cg));
	end

	always_ff @(posedge clk) begin
		join_ok <= row_ok || (cfg.mode && col_ok);
	end

endmodule

FILE: hw/rtl/box_proximity_clustering.sv
// ----------------------------------------------------------------------------
// box_proximity_clustering
// Loads a set of boxes, joins neighbor pairs into clusters, emits labels.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per box, tdata = {h, w, y, x}, tlast closes the set.
//   Boxes beyond MAX_BOXES are dropped; tuser on the results then reads 1.
//   cfg: index/data writes of row gap limit, column gap base and mode; always
//   ready, write only while the block is idle.
//   m_axis: after the closing beat, one beat per stored box in input order,
//   tdata = dense cluster number, tuser = overflow, tlast on the final one.
// Flow: box beats are taken back to back while loading. A set of N boxes
//   then runs pairs i < j through a single two-stage test unit, each pair
//   in states JRD, JEV, W1, W2; a join of two different labels adds a merge
//   sweep over all N entries (KRD, KWR each), and each row first fetches box
//   i (IRD, ILAT). Each result is read in ERD, ELAB and, if its label is not
//   its own index, EDEN; a stalled receiver holds the result beat.
// Input is not accepted while a set is processed or emitted.
// Reset: empty set, overflow clear, registers to 50, 27 and mode 1.
// ----------------------------------------------------------------------------
module box_proximity_clustering import bpc_pkg::*; #(
	parameter int MAX_BOXES = 64,
	parameter int COORD_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// box_x, box_y, box_width, box_height, zero pad
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
	input  logic                                   s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// cluster_number, zero pad
	output logic [7:0]                             m_axis_tdata,
	// overflow
	output logic                                   m_axis_tuser,
	output logic                                   m_axis_tlast,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [1:0]                             cfg_index,
	input  logic [GAP_BITS-1:0]                    cfg_data
);

	localparam int CB = COORD_BITS;
	localparam int BW = 4 * CB;
	localparam int IW = $clog2(MAX_BOXES);
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] ONE = CW'(1);
	localparam logic [CW-1:0] CAP = CW'(MAX_BOXES);
	localparam logic [IW-1:0] IONE = IW'(1);

	localparam logic [3:0] S_LOAD = 4'd0;
	localparam logic [3:0] S_IRD  = 4'd1;
	localparam logic [3:0] S_ILAT = 4'd2;
	localparam logic [3:0] S_JRD  = 4'd3;
	localparam logic [3:0] S_JEV  = 4'd4;
	localparam logic [3:0] S_W1   = 4'd5;
	localparam logic [3:0] S_W2   = 4'd6;
	localparam logic [3:0] S_KRD  = 4'd7;
	localparam logic [3:0] S_KWR  = 4'd8;
	localparam logic [3:0] S_ERD  = 4'd9;
	localparam logic [3:0] S_ELAB = 4'd10;
	localparam logic [3:0] S_EDEN = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q, n_q, i_q, j_q, k_q, e_q;
	logic [IW-1:0] nxt_q, li_q, lj_q, hi_q, lo_q;
	logic          ovf_q;
	logic [BW-1:0] bi_q;
	rule_cfg_t     cfg_q;

	logic [IW-1:0] out_cl_q;
	logic          out_vld_q, out_last_q, out_ovf_q;

	logic [BW-1:0] box_mem [MAX_BOXES];
	logic [IW-1:0] lab_mem [MAX_BOXES];
	logic [IW-1:0] den_mem [MAX_BOXES];
	logic [BW-1:0] box_rd;
	logic [IW-1:0] lab_a, lab_b, den_rd;

	logic          in_acc, out_acc, cfg_acc;
	logic [IW-1:0] box_ra, lab_ra, lab_wa, lab_wd;
	logic          lab_we;
	logic          unit_done, unit_join;
	logic [IW+CLUSTER_BITS-1:0] cl_ext;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = out_vld_q && m_axis_tready;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign s_axis_tready = (state_q == S_LOAD);
	assign cfg_ready = 1'b1;

	assign cl_ext = {{CLUSTER_BITS{1'b0}}, out_cl_q};
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {{(8-CLUSTER_BITS){1'b0}}, cl_ext[CLUSTER_BITS-1:0]};
	assign m_axis_tuser = out_ovf_q;
	assign m_axis_tlast = out_last_q;

	always_comb begin
		box_ra = j_q[IW-1:0];
		if (state_q == S_IRD) begin
			box_ra = i_q[IW-1:0];
		end
		lab_ra = i_q[IW-1:0];
		case (state_q)
			S_KRD: lab_ra = k_q[IW-1:0];
			S_ERD: lab_ra = e_q[IW-1:0];
			default: lab_ra = i_q[IW-1:0];
		endcase
		lab_we = 1'b0;
		lab_wa = cnt_q[IW-1:0];
		lab_wd = cnt_q[IW-1:0];
		if (state_q == S_LOAD) begin
			lab_we = in_acc && (cnt_q < CAP);
		end else if (state_q == S_KWR) begin
			lab_we = (lab_a == hi_q);
			lab_wa = k_q[IW-1:0];
			lab_wd = lo_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < CAP)) begin
			box_mem[cnt_q[IW-1:0]] <= s_axis_tdata[BW-1:0];
		end
		box_rd <= box_mem[box_ra];
	end

	always_ff @(posedge clk) begin
		if (lab_we) begin
			lab_mem[lab_wa] <= lab_wd;
		end
		lab_a <= lab_mem[lab_ra];
		lab_b <= lab_mem[j_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_ELAB) && (lab_a == e_q[IW-1:0])) begin
			den_mem[e_q[IW-1:0]] <= nxt_q;
		end
		den_rd <= den_mem[lab_a];
	end

	bpc_pair_test #(.COORD_BITS(CB)) u_pair (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_JEV),
		.box_p   (bi_q),
		.box_q   (box_rd),
		.cfg     (cfg_q),
		.done    (unit_done),
		.join_ok (unit_join)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_gap <= ROW_GAP_RST;
			cfg_q.col_base <= COL_BASE_RST;
			cfg_q.mode <= 1'b1;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_ROW_GAP: cfg_q.row_gap <= cfg_data;
				REG_COL_BASE: cfg_q.col_base <= cfg_data;
				REG_MODE: cfg_q.mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ILAT) begin
			bi_q <= box_rd;
		end
		if (state_q == S_JEV) begin
			li_q <= lab_a;
			lj_q <= lab_b;
		end
		if (state_q == S_W2) begin
			hi_q <= (li_q > lj_q) ? li_q : lj_q;
			lo_q <= (li_q > lj_q) ? lj_q : li_q;
		end
		if (state_q == S_ELAB) begin
			out_cl_q <= nxt_q;
			out_ovf_q <= ovf_q;
			out_last_q <= ((e_q + ONE) == n_q);
		end
		if (state_q == S_EDEN) begin
			out_cl_q <= den_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q <= '0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			e_q <= '0;
			nxt_q <= '0;
			ovf_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (cnt_q < CAP) begin
							cnt_q <= cnt_q + ONE;
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							n_q <= (cnt_q < CAP) ? cnt_q + ONE : cnt_q;
							i_q <= '0;
							state_q <= S_IRD;
						end
					end
				end
				S_IRD: begin
					if ((i_q + ONE) >= n_q) begin
						e_q <= '0;
						nxt_q <= '0;
						state_q <= S_ERD;
					end else begin
						j_q <= i_q + ONE;
						state_q <= S_ILAT;
					end
				end
				S_ILAT: state_q <= S_JRD;
				S_JRD: state_q <= S_JEV;
				S_JEV: state_q <= S_W1;
				S_W1: state_q <= S_W2;
				S_W2: begin
					if (unit_done && unit_join && (li_q != lj_q)) begin
						k_q <= '0;
						state_q <= S_KRD;
					end else if ((j_q + ONE) < n_q) begin
						j_q <= j_q + ONE;
						state_q <= S_JRD;
					end else begin
						i_q <= i_q + ONE;
						state_q <= S_IRD;
					end
				end
				S_KRD: state_q <= S_KWR;
				S_KWR: begin
					if ((k_q + ONE) < n_q) begin
						k_q <= k_q + ONE;
						state_q <= S_KRD;
					end else if ((j_q + ONE) < n_q) begin
						j_q <= j_q + ONE;
						state_q <= S_JRD;
					end else begin
						i_q <= i_q + ONE;
						state_q <= S_IRD;
					end
				end
				S_ERD: state_q <= S_ELAB;
				S_ELAB: begin
					if (lab_a == e_q[IW-1:0]) begin
						nxt_q <= nxt_q + IONE;
						out_vld_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_EDEN;
					end
				end
				S_EDEN: begin
					out_vld_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						out_vld_q <= 1'b0;
						if ((e_q + ONE) == n_q) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							e_q <= e_q + ONE;
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

FILE: hw/rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks on the clustering block's stream behavior.
// ----------------------------------------------------------------------------
module bpc_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tlast
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while result pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("not ready for next set after final result");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !m_axis_tvalid)
		else $error("result beats without label fetch gap");

endmodule

bind box_proximity_clustering bpc_checker u_bpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tlast  (m_axis_tlast)
);
